// File: rtl/sstic_pkg.sv
// ----------------------------------------------------------------------------
// sstic_pkg
// Types, codes and constant tables for the scaled-Mach coefficient block.
// ----------------------------------------------------------------------------
package sstic_pkg;

  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned TABLE_POINTS = 52;
  localparam int unsigned HORNER_STEPS = 6;
  localparam int unsigned HORNER_DIV [HORNER_STEPS] = '{156, 110, 72, 42, 20, 6};

  localparam logic [16:0] ANGLE_LIMIT = 17'd102943;
  localparam logic [18:0] X_CLAMP     = 19'd327680;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NEG   = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam logic [1:0] ARG_NONE  = 2'd0;
  localparam logic [1:0] ARG_MACH  = 2'd1;
  localparam logic [1:0] ARG_ANGLE = 2'd2;

  typedef struct packed {
    logic signed [31:0] mach;
    logic signed [19:0] angle;
  } in_t;

  typedef struct packed {
    logic [17:0] coefficient;
    logic [31:0] scaled_mach;
    logic [1:0]  status;
    logic [1:0]  bad_argument;
  } out_t;

  typedef struct packed {
    logic [30:0] mach;
    logic [30:0] t;
    logic [1:0]  status;
    logic [1:0]  bad_argument;
  } side_t;

  typedef struct packed {
    logic [31:0] scaled_mach;
    logic [1:0]  status;
    logic [1:0]  bad_argument;
  } meta_t;

  function automatic logic [12:0] bp_milli(input logic [5:0] idx);
    logic [12:0] r;
    case (idx)
      6'd0: r = 13'd0;       6'd1: r = 13'd50;      6'd2: r = 13'd100;
      6'd3: r = 13'd150;     6'd4: r = 13'd200;     6'd5: r = 13'd250;
      6'd6: r = 13'd300;     6'd7: r = 13'd325;     6'd8: r = 13'd350;
      6'd9: r = 13'd375;     6'd10: r = 13'd400;    6'd11: r = 13'd425;
      6'd12: r = 13'd450;    6'd13: r = 13'd475;    6'd14: r = 13'd500;
      6'd15: r = 13'd525;    6'd16: r = 13'd550;    6'd17: r = 13'd575;
      6'd18: r = 13'd600;    6'd19: r = 13'd625;    6'd20: r = 13'd650;
      6'd21: r = 13'd675;    6'd22: r = 13'd700;    6'd23: r = 13'd750;
      6'd24: r = 13'd800;    6'd25: r = 13'd850;    6'd26: r = 13'd900;
      6'd27: r = 13'd1000;   6'd28: r = 13'd1100;   6'd29: r = 13'd1200;
      6'd30: r = 13'd1400;   6'd31: r = 13'd1500;   6'd32: r = 13'd1600;
      6'd33: r = 13'd1700;   6'd34: r = 13'd1800;   6'd35: r = 13'd1900;
      6'd36: r = 13'd2000;   6'd37: r = 13'd2200;   6'd38: r = 13'd2400;
      6'd39: r = 13'd2600;   6'd40: r = 13'd2800;   6'd41: r = 13'd3000;
      6'd42: r = 13'd3200;   6'd43: r = 13'd3400;   6'd44: r = 13'd3600;
      6'd45: r = 13'd3800;   6'd46: r = 13'd4000;   6'd47: r = 13'd4200;
      6'd48: r = 13'd4400;   6'd49: r = 13'd4600;   6'd50: r = 13'd4800;
      6'd51: r = 13'd5000;
      default: r = 13'd0;
    endcase
    return r;
  endfunction

  function automatic logic [33:0] tab_val(input logic [5:0] idx);
    logic [33:0] r;
    case (idx)
      6'd0: r = 34'd4630980768;   6'd1: r = 34'd4677800375;
      6'd2: r = 34'd4752468799;   6'd3: r = 34'd4907471063;
      6'd4: r = 34'd5135048645;   6'd5: r = 34'd5443815045;
      6'd6: r = 34'd5930182839;   6'd7: r = 34'd6229398816;
      6'd8: r = 34'd6684082972;   6'd9: r = 34'd7353032292;
      6'd10: r = 34'd8227447287;  6'd11: r = 34'd9238335910;
      6'd12: r = 34'd10205221098; 6'd13: r = 34'd11044354118;
      6'd14: r = 34'd11668842695; 6'd15: r = 34'd12165998141;
      6'd16: r = 34'd12621934490; 6'd17: r = 34'd12956266708;
      6'd18: r = 34'd13207425375; 6'd19: r = 34'd13398701109;
      6'd20: r = 34'd13573063275; 6'd21: r = 34'd13709033596;
      6'd22: r = 34'd13810151545; 6'd23: r = 34'd13968540670;
      6'd24: r = 34'd14037035942; 6'd25: r = 34'd14037043230;
      6'd26: r = 34'd13982921821; 6'd27: r = 34'd13846037666;
      6'd28: r = 34'd13687419818; 6'd29: r = 34'd13528801970;
      6'd30: r = 34'd13241592698; 6'd31: r = 34'd13110420640;
      6'd32: r = 34'd13019658260; 6'd33: r = 34'd12922521728;
      6'd34: r = 34'd12848638193; 6'd35: r = 34'd12821298143;
      6'd36: r = 34'd12798944057; 6'd37: r = 34'd12762690842;
      6'd38: r = 34'd12750335937; 6'd39: r = 34'd12754210300;
      6'd40: r = 34'd12757510251; 6'd41: r = 34'd12755937458;
      6'd42: r = 34'd12752076052; 6'd43: r = 34'd12747228018;
      6'd44: r = 34'd12741876471; 6'd45: r = 34'd12736233243;
      6'd46: r = 34'd12730406014; 6'd47: r = 34'd12724455664;
      6'd48: r = 34'd12718419389; 6'd49: r = 34'd12712321282;
      6'd50: r = 34'd12706177664; 6'd51: r = 34'd12700000000;
      default: r = 34'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/sstic_horner_cell.sv
// ----------------------------------------------------------------------------
// sstic_horner_cell
// One Horner step of the sine polynomial: p' = 1 - (t2*p)/K, two stages.
// ----------------------------------------------------------------------------
module sstic_horner_cell #(
  parameter int unsigned K = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_i,
  input  logic [31:0]        t2_i,
  input  logic [30:0]        p_i,
  input  sstic_pkg::side_t   side_i,
  output logic               valid_o,
  output logic [31:0]        t2_o,
  output logic [30:0]        p_o,
  output sstic_pkg::side_t   side_o
);

  localparam logic [39:0] RECIP = 40'(((64'd1 << 40) + 64'(K) - 64'd1) / 64'(K));

  logic             va_r;
  logic [31:0]      qa_r;
  logic [31:0]      t2a_r;
  sstic_pkg::side_t sidea_r;
  logic [62:0]      prod_a;
  logic [71:0]      prod_b;

  assign prod_a = 63'(t2_i) * 63'(p_i);
  assign prod_b = 72'(qa_r) * 72'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en) begin
      va_r    <= valid_i;
      valid_o <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qa_r    <= prod_a[61:30];
      t2a_r   <= t2_i;
      sidea_r <= side_i;
      t2_o    <= t2a_r;
      side_o  <= sidea_r;
      p_o     <= 31'h4000_0000 - prod_b[70:40];
    end
  end

endmodule

// File: rtl/sstic_interp.sv
// ----------------------------------------------------------------------------
// sstic_interp
// Segment search and linear interpolation in the breakpoint table, with
// rounding to Q2.16.
// ----------------------------------------------------------------------------
module sstic_interp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_i,
  input  logic [18:0]        xc_i,
  input  sstic_pkg::meta_t   meta_i,
  output logic               valid_o,
  output sstic_pkg::out_t    out_o
);

  localparam logic [32:0] M25    = 33'd5497558139;
  localparam logic [31:0] R_DIV  = 32'd3689348814;
  localparam logic [23:0] D_DIV  = 24'd9765625;
  localparam logic [50:0] HALF   = 51'd5000000000;

  logic [5:0]        v_r;
  sstic_pkg::meta_t  m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;

  // stage 0
  logic [28:0] xk;
  logic [5:0]  seg;
  logic [28:0] xk0_r;
  logic [5:0]  seg0_r;

  always_comb begin
    xk  = 29'(xc_i) * 29'd1000;
    seg = 6'd0;
    for (int j = 1; j <= sstic_pkg::TABLE_POINTS - 2; j++) begin
      if ({sstic_pkg::bp_milli(6'(j)), 16'b0} <= xk) seg = 6'(j);
    end
  end

  // stage 1
  logic [12:0]        bp0, bp1, dm;
  logic [33:0]        tv0, tv1;
  logic signed [34:0] dv;
  logic [34:0]        dv_abs;
  logic [1:0]         sh;
  logic [23:0]        n1_r;
  logic [29:0]        mag1_r;
  logic               neg1_r;
  logic [1:0]         sh1_r;
  logic [33:0]        v1_r;

  always_comb begin
    bp0    = sstic_pkg::bp_milli(seg0_r);
    bp1    = sstic_pkg::bp_milli(seg0_r + 6'd1);
    tv0    = sstic_pkg::tab_val(seg0_r);
    tv1    = sstic_pkg::tab_val(seg0_r + 6'd1);
    dm     = bp1 - bp0;
    dv     = $signed({1'b0, tv1}) - $signed({1'b0, tv0});
    dv_abs = dv[34] ? 35'(-dv) : 35'(dv);
    case (dm)
      13'd25:  sh = 2'd0;
      13'd50:  sh = 2'd1;
      13'd100: sh = 2'd2;
      13'd200: sh = 2'd3;
      default: sh = 2'd0;
    endcase
  end

  // stage 2
  logic [53:0] prod2_r;
  logic        neg2_r;
  logic [1:0]  sh2_r;
  logic [33:0] v2_r;

  // stage 3
  logic [34:0] qa;
  logic [66:0] prod3_r;
  logic        neg3_r;
  logic [33:0] v3_r;

  assign qa = 35'(prod2_r >> (6'd16 + 6'(sh2_r)));

  // stage 4
  logic [29:0]        q4;
  logic signed [35:0] y_s;
  logic [33:0]        y4;
  logic [50:0]        z4;
  logic [39:0]        w4_r;
  logic [31:0]        u4_r;

  always_comb begin
    q4  = prod3_r[66:37];
    y_s = neg3_r ? ($signed({2'b0, v3_r}) - $signed({6'b0, q4}))
                 : ($signed({2'b0, v3_r}) + $signed({6'b0, q4}));
    y4  = y_s[35] ? 34'd0 : y_s[33:0];
    z4  = {y4, 16'b0} + HALF;
  end

  // stage 5
  logic [63:0] prod5;
  logic [16:0] est5_r;
  logic [39:0] w5_r;

  assign prod5 = 64'(u4_r) * 64'(R_DIV);

  // stage 6
  logic [39:0] rem6;
  logic [17:0] coef6;

  always_comb begin
    rem6  = w5_r - 40'(est5_r) * 40'(D_DIV);
    coef6 = (rem6 >= 40'(D_DIV)) ? 18'(est5_r) + 18'd1 : 18'(est5_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      valid_o <= 1'b0;
    end else if (en) begin
      v_r     <= {v_r[4:0], valid_i};
      valid_o <= v_r[5];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xk0_r   <= xk;
      seg0_r  <= seg;
      m0_r    <= meta_i;
      n1_r    <= 24'(xk0_r - {bp0, 16'b0});
      mag1_r  <= dv_abs[29:0];
      neg1_r  <= dv[34];
      sh1_r   <= sh;
      v1_r    <= tv0;
      m1_r    <= m0_r;
      prod2_r <= 54'(mag1_r) * 54'(n1_r);
      neg2_r  <= neg1_r;
      sh2_r   <= sh1_r;
      v2_r    <= v1_r;
      m2_r    <= m1_r;
      prod3_r <= 67'(qa) * 67'(M25);
      neg3_r  <= neg2_r;
      v3_r    <= v2_r;
      m3_r    <= m2_r;
      w4_r    <= z4[49:10];
      u4_r    <= z4[49:18];
      m4_r    <= m3_r;
      est5_r  <= prod5[63:47];
      w5_r    <= w4_r;
      m5_r    <= m4_r;
      out_o.coefficient  <= (m5_r.status == sstic_pkg::STATUS_OK) ? coef6 : 18'd0;
      out_o.scaled_mach  <= m5_r.scaled_mach;
      out_o.status       <= m5_r.status;
      out_o.bad_argument <= m5_r.bad_argument;
    end
  end

endmodule

// File: rtl/sine_scaled_table_interp_coefficient_top.sv
// ----------------------------------------------------------------------------
// sine_scaled_table_interp_coefficient_top
// Coefficient lookup from a Mach number scaled by the sine of an angle.
//
// Input channel in_valid/in_ready/in_data carries a Mach number (Q16.16) and
// an angle (Q4.16). Output channel out_valid/out_ready/out_data returns one
// transaction per input: coefficient (Q2.16), unclamped M*sin(angle)
// (Q16.16), status and the offending argument. Errors give zero values.
// The path is one pipeline: argument check, angle square, a chain of six
// Horner cells (two stages each), sine and scale multiplies, then seven
// interpolation stages ending in the output register: 23 register stages.
// Throughput is one transaction per cycle while the output is not stalled.
// The whole pipeline advances only when the output register is empty or
// being taken, so a stall at out_ready freezes every stage and drops
// in_ready the same cycle. Reset empties the pipeline.
// ----------------------------------------------------------------------------
module sine_scaled_table_interp_coefficient_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sstic_pkg::in_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output sstic_pkg::out_t  out_data
);

  localparam int unsigned N = sstic_pkg::HORNER_STEPS;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 0: argument checks
  sstic_pkg::side_t side0, s0_r;
  logic             v0_r;

  always_comb begin
    side0.mach         = in_data.mach[30:0];
    side0.t            = {in_data.angle[16:0], 14'b0};
    side0.status       = sstic_pkg::STATUS_OK;
    side0.bad_argument = sstic_pkg::ARG_NONE;
    if (in_data.mach[31]) begin
      side0.status       = sstic_pkg::STATUS_NEG;
      side0.bad_argument = sstic_pkg::ARG_MACH;
    end else if (in_data.angle[19]) begin
      side0.status       = sstic_pkg::STATUS_NEG;
      side0.bad_argument = sstic_pkg::ARG_ANGLE;
    end else if (in_data.angle[18:0] > 19'(sstic_pkg::ANGLE_LIMIT)) begin
      side0.status       = sstic_pkg::STATUS_RANGE;
      side0.bad_argument = sstic_pkg::ARG_ANGLE;
    end
  end

  // stage 1: t squared
  logic [61:0]      tsq;
  logic             v1_r;
  logic [31:0]      t2_1_r;
  sstic_pkg::side_t s1_r;

  assign tsq = 62'(s0_r.t) * 62'(s0_r.t);

  // Horner chain
  logic             hv   [N+1];
  logic [31:0]      ht2  [N+1];
  logic [30:0]      hp   [N+1];
  sstic_pkg::side_t hs   [N+1];

  assign hv[0]  = v1_r;
  assign ht2[0] = t2_1_r;
  assign hp[0]  = 31'h4000_0000;
  assign hs[0]  = s1_r;

  for (genvar g = 0; g < N; g++) begin : g_horner
    sstic_horner_cell #(.K(sstic_pkg::HORNER_DIV[g])) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (hv[g]),
      .t2_i    (ht2[g]),
      .p_i     (hp[g]),
      .side_i  (hs[g]),
      .valid_o (hv[g+1]),
      .t2_o    (ht2[g+1]),
      .p_o     (hp[g+1]),
      .side_o  (hs[g+1])
    );
  end

  // sine, then scale
  logic [61:0]      sprod;
  logic             vs_r;
  logic [30:0]      sin_r;
  sstic_pkg::side_t ss_r;
  logic [61:0]      xprod;
  logic [31:0]      x;
  logic             vx_r;
  logic [18:0]      xc_r;
  sstic_pkg::meta_t mx_r;
  logic             ok_s;

  assign sprod = 62'(hs[N].t) * 62'(hp[N]);
  assign xprod = 62'(ss_r.mach) * 62'(sin_r);
  assign x     = xprod[61:30];
  assign ok_s  = ss_r.status == sstic_pkg::STATUS_OK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      vs_r <= 1'b0;
      vx_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      vs_r <= hv[N];
      vx_r <= vs_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r                  <= side0;
      t2_1_r                <= tsq[61:30];
      s1_r                  <= s0_r;
      sin_r                 <= sprod[60:30];
      ss_r                  <= hs[N];
      xc_r                  <= !ok_s ? 19'd0 :
                               (x > 32'(sstic_pkg::X_CLAMP)) ? sstic_pkg::X_CLAMP : x[18:0];
      mx_r.scaled_mach      <= ok_s ? x : 32'd0;
      mx_r.status           <= ss_r.status;
      mx_r.bad_argument     <= ss_r.bad_argument;
    end
  end

  sstic_interp u_interp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (vx_r),
    .xc_i    (xc_r),
    .meta_i  (mx_r),
    .valid_o (out_valid),
    .out_o   (out_data)
  );

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != sstic_pkg::STATUS_OK |->
      out_data.coefficient == 18'd0 && out_data.scaled_mach == 32'd0)
    else $error("error transaction with nonzero values");
  a_ok_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == sstic_pkg::STATUS_OK |->
      out_data.bad_argument == sstic_pkg::ARG_NONE)
    else $error("ok status with bad argument");
  a_range_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == sstic_pkg::STATUS_RANGE |->
      out_data.bad_argument == sstic_pkg::ARG_ANGLE)
    else $error("range error not on angle");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule
